// ===== sv/rrht_pkg.sv =====
// Shared definitions for the rounded rectangle hit test core.
// Holds the default coordinate width and the per-point flag group.
// No dependencies.
package rrht_pkg;

  localparam int COORD_BITS_DEF = 16;

  // Flags that travel with one probe point into the corner test
  typedef struct packed {
    logic inbox;  // point lies in the plain holder rectangle
    logic plain;  // radius is zero or negative: square corners
  } pt_flags_t;

endpackage

// ===== sv/rrht_point.sv =====
// Three-stage corner test for one probe point against the rounded holder.
// Takes arc centers, squared radius and flags from the top level.
// Depends on rrht_pkg.
module rrht_point #(
  parameter int CW = rrht_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic signed [CW-1:0]  x,
  input  logic signed [CW-1:0]  y,
  input  logic signed [CW+1:0]  cxl,
  input  logic signed [CW+1:0]  cxr,
  input  logic signed [CW+1:0]  cyt,
  input  logic signed [CW+1:0]  cyb,
  input  logic [2*CW-1:0]       rr,
  input  rrht_pkg::pt_flags_t   flags,
  output logic                  ok
);
  import rrht_pkg::*;

  // Stage 1: distances to both candidate centers on each axis
  logic [CW+2:0] dxl_w, dxr_w, dyt_w, dyb_w;
  logic [CW+2:0] dxl_a, dxr_a, dyt_a, dyb_a;

  assign dxl_w = {{3{x[CW-1]}}, x} - {cxl[CW+1], cxl};
  assign dxr_w = {{3{x[CW-1]}}, x} - {cxr[CW+1], cxr};
  assign dyt_w = {{3{y[CW-1]}}, y} - {cyt[CW+1], cyt};
  assign dyb_w = {{3{y[CW-1]}}, y} - {cyb[CW+1], cyb};

  assign dxl_a = dxl_w[CW+2] ? (~dxl_w + 1'b1) : dxl_w;
  assign dxr_a = dxr_w[CW+2] ? (~dxr_w + 1'b1) : dxr_w;
  assign dyt_a = dyt_w[CW+2] ? (~dyt_w + 1'b1) : dyt_w;
  assign dyb_a = dyb_w[CW+2] ? (~dyb_w + 1'b1) : dyb_w;

  logic [CW-1:0]   p1_dxl, p1_dxr, p1_dyt, p1_dyb;
  logic            p1_nl, p1_nr, p1_nt, p1_nb;
  logic [2*CW-1:0] p1_rr;
  pt_flags_t       p1_flags;

  // Inside a corner square the distance never exceeds the radius,
  // so the low CW bits carry it exactly.
  always_ff @(posedge clk) begin
    p1_dxl   <= dxl_a[CW-1:0];
    p1_dxr   <= dxr_a[CW-1:0];
    p1_dyt   <= dyt_a[CW-1:0];
    p1_dyb   <= dyb_a[CW-1:0];
    p1_nl    <= ($signed({x[CW-1], x[CW-1], x}) <= cxl);
    p1_nr    <= ($signed({x[CW-1], x[CW-1], x}) >= cxr);
    p1_nt    <= ($signed({y[CW-1], y[CW-1], y}) <= cyt);
    p1_nb    <= ($signed({y[CW-1], y[CW-1], y}) >= cyb);
    p1_rr    <= rr;
    p1_flags <= flags;
  end

  // Stage 2: pick the deciding corner in priority order, square distances
  logic          corner;
  logic [CW-1:0] dx_sel, dy_sel;

  always_comb begin
    corner = 1'b1;
    dx_sel = p1_dxl;
    dy_sel = p1_dyt;
    if (p1_nl && p1_nt) begin
      dx_sel = p1_dxl;
    end else if (p1_nl && p1_nb) begin
      dy_sel = p1_dyb;
    end else if (p1_nr && p1_nb) begin
      dx_sel = p1_dxr;
      dy_sel = p1_dyb;
    end else if (p1_nr && p1_nt) begin
      dx_sel = p1_dxr;
    end else begin
      corner = 1'b0;
    end
  end

  logic [2*CW-1:0] p2_dx2, p2_dy2, p2_rr;
  logic            p2_corner;
  pt_flags_t       p2_flags;

  always_ff @(posedge clk) begin
    p2_dx2    <= dx_sel * dx_sel;
    p2_dy2    <= dy_sel * dy_sel;
    p2_rr     <= p1_rr;
    p2_corner <= corner;
    p2_flags  <= p1_flags;
  end

  // Stage 3: circle compare
  logic [2*CW:0] dist2;
  assign dist2 = {1'b0, p2_dx2} + {1'b0, p2_dy2};

  always_ff @(posedge clk) begin
    ok <= p2_flags.inbox &&
          (p2_flags.plain || !p2_corner || (dist2 <= {1'b0, p2_rr}));
  end

endmodule

// ===== sv/rounded_rect_hit_test_core.sv =====
// Rounded rectangle hit test: point or inner rectangle against a holder.
// Top level; instantiates rrht_point four times. Depends on rrht_pkg.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+----------------------
//   request  | kind, holder_*, corner_radius, probe_*  | start high, busy low
//   result   | inside_res                              | done, one cycle
//
// One item enters per cycle; its result leaves the last stage with done.
// The pipeline has seven register stages: box checks, radius clamp,
// centers and squared radius, three corner-test stages, final combine.
// busy stays low: the pipeline never stalls, and the receiver takes every
// result in the cycle done is high. rst clears the valid bits only.
module rounded_rect_hit_test_core #(
  parameter int COORD_BITS = rrht_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic signed [COORD_BITS-1:0] holder_left,
  input  logic signed [COORD_BITS-1:0] holder_top,
  input  logic signed [COORD_BITS-1:0] holder_right,
  input  logic signed [COORD_BITS-1:0] holder_bottom,
  input  logic signed [COORD_BITS-1:0] corner_radius,
  input  logic signed [COORD_BITS-1:0] probe_left,
  input  logic signed [COORD_BITS-1:0] probe_top,
  input  logic signed [COORD_BITS-1:0] probe_right,
  input  logic signed [COORD_BITS-1:0] probe_bottom,
  output logic                         done,
  output logic                         inside_res
);
  import rrht_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int LAT = 7;

  assign busy = 1'b0;

  // Valid bits
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  assign done = vld[LAT-1];

  // Stage 1: half sides, radius sign, plain box checks
  logic [CW+1:0] w_x, w_y;

  assign w_x = {{2{holder_right[CW-1]}}, holder_right}
             - {{2{holder_left[CW-1]}}, holder_left} + 1'b1;
  assign w_y = {{2{holder_bottom[CW-1]}}, holder_bottom}
             - {{2{holder_top[CW-1]}}, holder_top} + 1'b1;

  logic signed [CW-1:0] s1_l, s1_t, s1_rt, s1_b;
  logic signed [CW-1:0] s1_pl, s1_pt, s1_pr, s1_pb;
  logic [CW-1:0]        s1_hw, s1_hh, s1_rad;
  logic                 s1_rad_pos, s1_kind;
  logic                 s1_xin_l, s1_xin_r, s1_yin_t, s1_yin_b;

  always_ff @(posedge clk) begin
    s1_l       <= holder_left;
    s1_t       <= holder_top;
    s1_rt      <= holder_right;
    s1_b       <= holder_bottom;
    s1_pl      <= probe_left;
    s1_pt      <= probe_top;
    s1_pr      <= probe_right;
    s1_pb      <= probe_bottom;
    s1_hw      <= w_x[CW:1];
    s1_hh      <= w_y[CW:1];
    s1_rad     <= corner_radius;
    s1_rad_pos <= !corner_radius[CW-1] && (corner_radius != '0);
    s1_kind    <= kind;
    s1_xin_l   <= (probe_left >= holder_left) && (probe_left <= holder_right);
    s1_xin_r   <= (probe_right >= holder_left) && (probe_right <= holder_right);
    s1_yin_t   <= (probe_top >= holder_top) && (probe_top <= holder_bottom);
    s1_yin_b   <= (probe_bottom >= holder_top) && (probe_bottom <= holder_bottom);
  end

  // Stage 2: clamp the radius
  logic [CW-1:0] r_clamp;

  always_comb begin
    r_clamp = (s1_hw < s1_hh) ? s1_hw : s1_hh;
    if (s1_rad_pos && (s1_rad < r_clamp)) begin
      r_clamp = s1_rad;
    end
  end

  logic signed [CW-1:0] s2_l, s2_t, s2_rt, s2_b;
  logic signed [CW-1:0] s2_pl, s2_pt, s2_pr, s2_pb;
  logic [CW-1:0]        s2_r;
  logic                 s2_plain, s2_kind;
  logic                 s2_xin_l, s2_xin_r, s2_yin_t, s2_yin_b;

  always_ff @(posedge clk) begin
    s2_l     <= s1_l;
    s2_t     <= s1_t;
    s2_rt    <= s1_rt;
    s2_b     <= s1_b;
    s2_pl    <= s1_pl;
    s2_pt    <= s1_pt;
    s2_pr    <= s1_pr;
    s2_pb    <= s1_pb;
    s2_r     <= r_clamp;
    s2_plain <= !s1_rad_pos;
    s2_kind  <= s1_kind;
    s2_xin_l <= s1_xin_l;
    s2_xin_r <= s1_xin_r;
    s2_yin_t <= s1_yin_t;
    s2_yin_b <= s1_yin_b;
  end

  // Stage 3: arc centers and squared radius
  logic signed [CW+1:0] s3_cxl, s3_cxr, s3_cyt, s3_cyb;
  logic [2*CW-1:0]      s3_rr;
  logic signed [CW-1:0] s3_pl, s3_pt, s3_pr, s3_pb;
  logic                 s3_kind;
  pt_flags_t            s3_f_lt, s3_f_rt, s3_f_lb, s3_f_rb;

  always_ff @(posedge clk) begin
    s3_cxl        <= $signed({{2{s2_l[CW-1]}}, s2_l} + {2'b00, s2_r});
    s3_cxr        <= $signed({{2{s2_rt[CW-1]}}, s2_rt} - {2'b00, s2_r});
    s3_cyt        <= $signed({{2{s2_t[CW-1]}}, s2_t} + {2'b00, s2_r});
    s3_cyb        <= $signed({{2{s2_b[CW-1]}}, s2_b} - {2'b00, s2_r});
    s3_rr         <= s2_r * s2_r;
    s3_pl         <= s2_pl;
    s3_pt         <= s2_pt;
    s3_pr         <= s2_pr;
    s3_pb         <= s2_pb;
    s3_kind       <= s2_kind;
    s3_f_lt.inbox <= s2_xin_l && s2_yin_t;
    s3_f_rt.inbox <= s2_xin_r && s2_yin_t;
    s3_f_lb.inbox <= s2_xin_l && s2_yin_b;
    s3_f_rb.inbox <= s2_xin_r && s2_yin_b;
    s3_f_lt.plain <= s2_plain;
    s3_f_rt.plain <= s2_plain;
    s3_f_lb.plain <= s2_plain;
    s3_f_rb.plain <= s2_plain;
  end

  // Stages 4 to 6: corner test, one unit per probe corner
  logic ok_lt, ok_rt, ok_lb, ok_rb;

  rrht_point #(.CW(CW)) u_pt_lt (
    .clk(clk), .x(s3_pl), .y(s3_pt),
    .cxl(s3_cxl), .cxr(s3_cxr), .cyt(s3_cyt), .cyb(s3_cyb),
    .rr(s3_rr), .flags(s3_f_lt), .ok(ok_lt)
  );

  rrht_point #(.CW(CW)) u_pt_rt (
    .clk(clk), .x(s3_pr), .y(s3_pt),
    .cxl(s3_cxl), .cxr(s3_cxr), .cyt(s3_cyt), .cyb(s3_cyb),
    .rr(s3_rr), .flags(s3_f_rt), .ok(ok_rt)
  );

  rrht_point #(.CW(CW)) u_pt_lb (
    .clk(clk), .x(s3_pl), .y(s3_pb),
    .cxl(s3_cxl), .cxr(s3_cxr), .cyt(s3_cyt), .cyb(s3_cyb),
    .rr(s3_rr), .flags(s3_f_lb), .ok(ok_lb)
  );

  rrht_point #(.CW(CW)) u_pt_rb (
    .clk(clk), .x(s3_pr), .y(s3_pb),
    .cxl(s3_cxl), .cxr(s3_cxr), .cyt(s3_cyt), .cyb(s3_cyb),
    .rr(s3_rr), .flags(s3_f_rb), .ok(ok_rb)
  );

  // Hold the test kind alongside the corner units
  logic [2:0] kind_dly;

  always_ff @(posedge clk) begin
    kind_dly <= {kind_dly[1:0], s3_kind};
  end

  // Stage 7: combine
  always_ff @(posedge clk) begin
    inside_res <= kind_dly[2] ? (ok_lt && ok_rt && ok_lb && ok_rb) : ok_lt;
  end

endmodule
